/* rtl/core/psba_pkg.sv */
// shared constants, codes and control types for the page slot bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
package psba_pkg;

   localparam int SLOTS     = 256;
   localparam int WORD_BITS = 32;
   localparam int WORDS     = SLOTS / WORD_BITS;
   localparam int WORD_W    = $clog2(WORDS);
   localparam int LANE_W    = $clog2(WORD_BITS);
   localparam int SLOT_W    = $clog2(SLOTS);

   localparam int KIND_W   = 3;
   localparam int RSLOT_W  = 8;
   localparam int CAP_W    = 9;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RECOVER = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd5;

   localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NOSPACE = 3'd1;
   localparam logic [STATUS_W-1:0] STS_INVARG  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_INVSLOT = 3'd3;
   localparam logic [STATUS_W-1:0] STS_ABSENT  = 3'd4;
   localparam logic [STATUS_W-1:0] STS_END     = 3'd5;

   typedef struct packed {
      logic load;
      logic advance;
      logic commit;
   } psba_cmd_type;

   typedef struct packed {
      logic done;
   } psba_status_type;

endpackage
`default_nettype wire

/* rtl/core/psba_datapath.sv */
// bitmap words, record count, capacity register, word scanner and result register
`timescale 1ns / 1ps
`default_nettype none
module psba_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [psba_pkg::CAP_W-1:0]     csr_wr_data,
   input  wire logic [psba_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [psba_pkg::RSLOT_W-1:0]   req_slot,
   input  wire psba_pkg::psba_cmd_type         cmd,
   output psba_pkg::psba_status_type           sts,
   output logic      [psba_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [psba_pkg::RSLOT_W-1:0]   rsp_result_slot,
   output logic      [psba_pkg::COUNT_W-1:0]   rsp_occupied_count,
   output logic                                rsp_page_full,
   output logic                                rsp_page_emptied
);
   import psba_pkg::*;

   logic [WORD_BITS-1:0]  bitmap_ff [WORDS];
   logic [COUNT_W-1:0]    count_ff;
   logic [CAP_W-1:0]      capacity_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [RSLOT_W-1:0]    slot_ff;
   logic [WORD_W-1:0]     word_idx_ff;

   logic [WORD_W-1:0]     word_idx_in;
   logic [CAP_W-1:0]      cap_eff;
   logic [WORD_BITS-1:0]  cur_word;
   logic [WORD_BITS-1:0]  cap_mask;
   logic [WORD_BITS-1:0]  start_mask;
   logic [WORD_BITS-1:0]  cand;
   logic                  hit;
   logic [LANE_W-1:0]     hit_lane;
   logic [SLOT_W-1:0]     found_slot;
   logic [LANE_W-1:0]     slot_lane;
   logic                  last_word;
   logic                  in_range;
   logic                  bit_set;
   logic                  full;

   logic                  done;
   logic [STATUS_W-1:0]   status_in;
   logic [RSLOT_W-1:0]    rslot_in;
   logic [COUNT_W-1:0]    count_in;
   logic                  emptied_in;
   logic                  full_in;
   logic                  clear_all;
   logic                  word_wr_en;
   logic [WORD_BITS-1:0]  word_wr_data;

   assign cap_eff    = (capacity_ff > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : capacity_ff;
   assign cur_word   = bitmap_ff[word_idx_ff];
   assign last_word  = (word_idx_ff == WORD_W'(WORDS - 1));
   assign slot_lane  = slot_ff[LANE_W-1:0];
   assign in_range   = ({1'b0, slot_ff} < cap_eff);
   assign bit_set    = cur_word[slot_lane];
   assign full       = (count_ff >= cap_eff);
   assign found_slot = {word_idx_ff, hit_lane};

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         cap_mask[b]   = ({1'b0, word_idx_ff, LANE_W'(b)} < cap_eff);
         start_mask[b] = ({word_idx_ff, LANE_W'(b)} >= SLOT_W'(slot_ff));
      end
      if (kind_ff == KIND_INSERT) begin
         cand = ~cur_word & cap_mask;
      end else begin
         cand = cur_word & cap_mask & start_mask;
      end
      hit      = 1'b0;
      hit_lane = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            hit      = 1'b1;
            hit_lane = LANE_W'(b);
         end
      end
   end

   always_comb begin
      done         = 1'b1;
      status_in    = STS_OK;
      rslot_in     = slot_ff;
      count_in     = count_ff;
      emptied_in   = 1'b0;
      clear_all    = 1'b0;
      word_wr_en   = 1'b0;
      word_wr_data = cur_word;
      unique case (kind_ff)
         KIND_CLEAR: begin
            clear_all = 1'b1;
            count_in  = '0;
         end
         KIND_INSERT: begin
            if (full) begin
               status_in = STS_NOSPACE;
            end else if (hit) begin
               word_wr_en             = 1'b1;
               word_wr_data[hit_lane] = 1'b1;
               count_in               = count_ff + COUNT_W'(1);
               rslot_in               = found_slot[RSLOT_W-1:0];
            end else begin
               status_in = STS_NOSPACE;
               done      = last_word;
            end
         end
         KIND_RECOVER: begin
            if (full || !in_range) begin
               status_in = STS_NOSPACE;
            end else begin
               word_wr_en              = 1'b1;
               word_wr_data[slot_lane] = 1'b1;
               count_in                = count_ff + COUNT_W'(1);
            end
         end
         KIND_DELETE: begin
            if (!in_range) begin
               status_in = STS_INVARG;
            end else if (bit_set) begin
               word_wr_en              = 1'b1;
               word_wr_data[slot_lane] = 1'b0;
               count_in   = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
               emptied_in = (count_in == '0);
            end else begin
               status_in = STS_ABSENT;
            end
         end
         KIND_LOOKUP: begin
            if (!in_range) begin
               status_in = STS_INVSLOT;
            end else if (!bit_set) begin
               status_in = STS_ABSENT;
            end
         end
         KIND_NEXT: begin
            if (hit) begin
               rslot_in = found_slot[RSLOT_W-1:0];
            end else begin
               status_in = STS_END;
               done      = last_word;
            end
         end
         default: begin
            status_in = STS_INVARG;
         end
      endcase
      full_in = (count_in >= cap_eff);
   end

   assign sts.done = done;

   always_comb begin
      if (cmd.load) begin
         word_idx_in = (req_kind == KIND_INSERT) ? '0 : req_slot[LANE_W +: WORD_W];
      end else if (cmd.advance) begin
         word_idx_in = word_idx_ff + WORD_W'(1);
      end else begin
         word_idx_in = word_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORDS; w++) begin
            bitmap_ff[w] <= '0;
         end
         count_ff    <= '0;
         capacity_ff <= CAP_RESET;
         word_idx_ff <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            count_ff <= count_in;
            if (clear_all) begin
               for (int w = 0; w < WORDS; w++) begin
                  bitmap_ff[w] <= '0;
               end
            end else if (word_wr_en) begin
               bitmap_ff[word_idx_ff] <= word_wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         slot_ff <= req_slot;
      end
      if (cmd.commit) begin
         rsp_status         <= status_in;
         rsp_result_slot    <= rslot_in;
         rsp_occupied_count <= count_in;
         rsp_page_full      <= full_in;
         rsp_page_emptied   <= emptied_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SLOTS))
      else $error("record count above slot total");

   a_no_advance_past_end: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !last_word)
      else $error("scan advanced past last word");

   a_clear_zeroes_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && kind_ff == KIND_CLEAR) |=> (count_ff == '0))
      else $error("clear left a nonzero count");

endmodule
`default_nettype wire

/* rtl/core/psba_ctrl.sv */
// controller state machine sequencing item load, word scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module psba_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire psba_pkg::psba_status_type  sts,
   output psba_pkg::psba_cmd_type          cmd
);
   import psba_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd.load    = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && sts.done && out_free;
   assign cmd.advance = (state_ff == ST_EXEC) && !sts.done;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before taken");

   a_load_enters_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_EXEC))
      else $error("accepted item did not start execution");

   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid without a commit");

endmodule
`default_nettype wire

/* rtl/core/page_slot_bitmap_allocator_unit.sv */
// top level of the page slot bitmap allocator: one item in flight, one result per item
// lookup, delete, recover insert and clear are loaded, then committed from EXEC once the result register is free
// insert and next-occupied scan one 32-bit bitmap word per cycle
// a new item is taken only once the last one is committed, the cycle after its result is loaded
// the result register lets the next item start while a result waits on rsp_ready
// reset (synchronous, active high) frees all slots, zeroes the count, capacity to 256
`timescale 1ns / 1ps
`default_nettype none
module page_slot_bitmap_allocator_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [psba_pkg::CAP_W-1:0]     csr_wr_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [psba_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [psba_pkg::RSLOT_W-1:0]   req_slot,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [psba_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [psba_pkg::RSLOT_W-1:0]   rsp_result_slot,
   output logic      [psba_pkg::COUNT_W-1:0]   rsp_occupied_count,
   output logic                                rsp_page_full,
   output logic                                rsp_page_emptied
);
   import psba_pkg::*;

   psba_cmd_type    cmd;
   psba_status_type sts;

   psba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psba_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_status         (rsp_status),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_occupied_count (rsp_occupied_count),
      .rsp_page_full      (rsp_page_full),
      .rsp_page_emptied   (rsp_page_emptied)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_page_slot_bitmap_allocator_unit.sv */
// testbench for the page slot bitmap allocator with random and directed items and a predictor
`timescale 1ns / 1ps
module tb_page_slot_bitmap_allocator_unit;
   import psba_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_MIX   = 1;
   localparam int MODE_DRAIN = 2;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 12;
   localparam int LONG_HOLD_AT = 120;
   localparam int LONG_HOLD    = 150;
   localparam int PRINT_MAX    = 40;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [RSLOT_W-1:0] slot;
   } page_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RSLOT_W-1:0]  rslot;
      logic [COUNT_W-1:0]  count;
      logic                full;
      logic                emptied;
   } page_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [RSLOT_W-1:0]  req_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [RSLOT_W-1:0]  rsp_result_slot;
   logic [COUNT_W-1:0]  rsp_occupied_count;
   logic                rsp_page_full;
   logic                rsp_page_emptied;

   // predictor state
   logic [SLOTS-1:0]   page_bits = '0;
   logic [COUNT_W-1:0] page_count = '0;
   logic [CAP_W-1:0]   capacity_now = CAP_RESET;

   page_op_type     pending_ops[$];
   page_result_type expected_results[$];
   int ops_queued = 0;
   int ops_taken = 0;
   int results_seen = 0;
   int errors_printed = 0;
   int cycle_cnt = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   bit quiet = 1'b0;
   bit fail_seen = 1'b0;

   page_slot_bitmap_allocator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_slot    (rsp_result_slot),
      .rsp_occupied_count (rsp_occupied_count),
      .rsp_page_full      (rsp_page_full),
      .rsp_page_emptied   (rsp_page_emptied)
   );

   always #5 clock = ~clock;

   function automatic int usable_slots();
      return (int'(capacity_now) > SLOTS) ? SLOTS : int'(capacity_now);
   endfunction

   // applies one operation to the page and returns what the block must report
   function automatic page_result_type apply_page_op(logic [KIND_W-1:0] kind,
                                                     logic [RSLOT_W-1:0] slot);
      page_result_type r;
      int usable;
      int i;
      bit hit;
      usable = usable_slots();
      r.status = STS_OK;
      r.rslot = slot;
      r.emptied = 1'b0;
      hit = 1'b0;
      case (kind)
         KIND_CLEAR: begin
            page_bits = '0;
            page_count = '0;
         end
         KIND_INSERT: begin
            r.status = STS_NOSPACE;
            if (int'(page_count) < usable) begin
               for (i = 0; i < usable; i++) begin
                  if (!hit && !page_bits[i]) begin
                     page_bits[i] = 1'b1;
                     page_count = page_count + 1'b1;
                     r.rslot = RSLOT_W'(i);
                     r.status = STS_OK;
                     hit = 1'b1;
                  end
               end
            end
         end
         KIND_RECOVER: begin
            if (int'(page_count) >= usable || int'(slot) >= usable) begin
               r.status = STS_NOSPACE;
            end else begin
               page_bits[slot] = 1'b1;
               page_count = page_count + 1'b1;
            end
         end
         KIND_DELETE: begin
            if (int'(slot) >= usable) begin
               r.status = STS_INVARG;
            end else if (page_bits[slot]) begin
               page_bits[slot] = 1'b0;
               if (page_count != 0) page_count = page_count - 1'b1;
               if (page_count == 0) r.emptied = 1'b1;
            end else begin
               r.status = STS_ABSENT;
            end
         end
         KIND_LOOKUP: begin
            if (int'(slot) >= usable) r.status = STS_INVSLOT;
            else if (!page_bits[slot]) r.status = STS_ABSENT;
         end
         KIND_NEXT: begin
            r.status = STS_END;
            for (i = int'(slot); i < usable; i++) begin
               if (!hit && page_bits[i]) begin
                  r.rslot = RSLOT_W'(i);
                  r.status = STS_OK;
                  hit = 1'b1;
               end
            end
         end
         default: begin
            r.status = STS_INVARG;
         end
      endcase
      r.count = page_count;
      r.full = (int'(page_count) >= usable);
      return r;
   endfunction

   function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         fail_seen = 1'b1;
         if (errors_printed < PRINT_MAX) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors_printed++;
         end
      end
   endfunction

   // sender: offers queued items, holds each until accepted
   always @(posedge clock) begin
      page_op_type op;
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_page_op(req_kind, req_slot));
            ops_taken++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 9);
            end else if (pending_ops.size() != 0) begin
               op = pending_ops.pop_front();
               req_kind <= op.kind;
               req_slot <= op.slot;
               nxt_valid = 1'b1;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // receiver: checks each result against the oldest expectation
   always @(posedge clock) begin
      page_result_type want;
      logic nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_seen = 1'b1;
               if (errors_printed < PRINT_MAX) begin
                  $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                           $time, rsp_status, rsp_result_slot);
                  errors_printed++;
               end
            end else begin
               want = expected_results.pop_front();
               check_field("status", 9'(want.status), 9'(rsp_status));
               check_field("result_slot", 9'(want.rslot), 9'(rsp_result_slot));
               check_field("occupied_count", want.count, rsp_occupied_count);
               check_field("page_full", 9'(want.full), 9'(rsp_page_full));
               check_field("page_emptied", 9'(want.emptied), 9'(rsp_page_emptied));
            end
            results_seen++;
         end
         if (results_seen == LONG_HOLD_AT && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            nxt_ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 8);
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
         rsp_ready <= nxt_ready;
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[page_slot_bitmap_allocator_unit] ERROR");
         $finish;
      end
   end

   task automatic queue_op(logic [KIND_W-1:0] kind, logic [RSLOT_W-1:0] slot);
      page_op_type op;
      op.kind = kind;
      op.slot = slot;
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   task automatic wait_drained();
      while (ops_taken != ops_queued || expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      capacity_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(int n, int mode);
      logic [KIND_W-1:0] kind;
      logic [RSLOT_W-1:0] slot;
      int pick;
      int hi;
      hi = (usable_slots() + 3 > 255) ? 255 : usable_slots() + 3;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (mode == MODE_FILL) pick = (pick < 70) ? 0 : (pick < 80) ? 35 : pick;
         else if (mode == MODE_DRAIN) pick = (pick < 50) ? 50 : pick;
         if (pick < 30) kind = KIND_INSERT;
         else if (pick < 42) kind = KIND_RECOVER;
         else if (pick < 62) kind = KIND_DELETE;
         else if (pick < 74) kind = KIND_LOOKUP;
         else if (pick < 86) kind = KIND_NEXT;
         else if (pick < 90) kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
         else if (pick < 92) kind = KIND_CLEAR;
         else kind = KIND_LOOKUP;
         if ($urandom_range(0, 9) == 0) slot = RSLOT_W'($urandom_range(0, 255));
         else slot = RSLOT_W'($urandom_range(0, hi));
         queue_op(kind, slot);
      end
   endtask

   task automatic run_phase(logic [CAP_W-1:0] cap, int n, int mode);
      wait_drained();
      write_capacity(cap);
      queue_random(n, mode);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty page, then a few records and every operation
      queue_op(KIND_LOOKUP, 8'd0);
      queue_op(KIND_LOOKUP, 8'd255);
      queue_op(KIND_NEXT, 8'd0);
      queue_op(KIND_DELETE, 8'd0);
      queue_op(KIND_INSERT, 8'd0);
      queue_op(KIND_INSERT, 8'd0);
      queue_op(KIND_INSERT, 8'd0);
      queue_op(KIND_RECOVER, 8'd255);
      queue_op(KIND_RECOVER, 8'd1);
      queue_op(KIND_LOOKUP, 8'd255);
      queue_op(KIND_LOOKUP, 8'd1);
      queue_op(KIND_NEXT, 8'd3);
      queue_op(KIND_NEXT, 8'd255);
      queue_op(KIND_DELETE, 8'd255);
      queue_op(KIND_DELETE, 8'd1);
      queue_op(KIND_DELETE, 8'd255);
      queue_op(KIND_SPARE_A, 8'd0);
      queue_op(KIND_SPARE_B, 8'd255);
      queue_op(KIND_CLEAR, 8'd170);
      queue_op(KIND_INSERT, 8'd85);
      queue_op(KIND_DELETE, 8'd0);
      queue_op(KIND_RECOVER, 8'd0);
      queue_op(KIND_RECOVER, 8'd0);
      queue_op(KIND_DELETE, 8'd0);
      queue_op(KIND_DELETE, 8'd0);

      run_phase(9'd256, 280, MODE_FILL);
      run_phase(9'd8, 80, MODE_MIX);
      run_phase(9'd1, 60, MODE_MIX);
      run_phase(9'd0, 30, MODE_MIX);
      run_phase(9'd300, 80, MODE_MIX);
      run_phase(9'd37, 120, MODE_MIX);
      run_phase(9'd511, 60, MODE_DRAIN);
      run_phase(9'd255, 150, MODE_FILL);
      wait_drained();
      quiet = 1'b1;
      write_capacity(9'd256);
      queue_random(40, MODE_MIX);
      wait_drained();

      if (!fail_seen) begin
         $display("[page_slot_bitmap_allocator_unit] OK");
      end else begin
         $display("[page_slot_bitmap_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
